// ===== design/ipm_pkg.sv =====
// Package: shared sizes, request and status codes, and payload types.
`timescale 1ns / 1ps
package ipm_pkg;

    // Capacity of each coefficient list
    localparam int MAX_TERMS    = 16;
    localparam int IDX_W        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W        = $clog2(MAX_TERMS + 1);
    localparam int COEF_W       = 16;
    localparam int PROD_W       = 2 * COEF_W;
    localparam int ACC_W        = 36;
    localparam int K_W          = 5;
    localparam int CMP_W        = ((CNT_W + 1 > K_W) ? CNT_W + 1 : K_W) + 1;
    localparam int RESULT_LIMIT = 31;

    // Request codes
    localparam logic [1:0] REQ_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] REQ_LOAD_SECOND = 2'd1;
    localparam logic [1:0] REQ_COMPUTE     = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    typedef struct packed {
        logic        [1:0]        req_type;
        logic signed [COEF_W-1:0] coef_value;
    } t_ipm_req;

    typedef struct packed {
        logic signed [ACC_W-1:0] product_coef;
        logic        [K_W-1:0]   coef_index;
        logic                    last_coef;
        logic        [1:0]       status;
    } t_ipm_result;

    // Controller to datapath
    typedef struct packed {
        logic             load_first;
        logic             load_second;
        logic             acc_clear;
        logic             issue;
        logic [IDX_W-1:0] first_addr;
        logic [IDX_W-1:0] second_addr;
        logic             emit;
        logic             emit_empty;
        logic             last;
        logic [K_W-1:0]   index;
    } t_ipm_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] first_count;
        logic [CNT_W-1:0] second_count;
    } t_ipm_stat;

endpackage

// ===== design/ipm_datapath.sv =====
// Datapath: coefficient memories, list counts, multiply-accumulate pipeline, result register.
`timescale 1ns / 1ps
module ipm_datapath
    import ipm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ipm_cmd                i_cmd,
    input  logic signed [COEF_W-1:0] i_coef,
    output t_ipm_stat               o_stat,
    output t_ipm_result             o_result,
    output logic                    o_valid
);

    logic signed [COEF_W-1:0] r_first_mem  [MAX_TERMS];
    logic signed [COEF_W-1:0] r_second_mem [MAX_TERMS];
    logic [CNT_W-1:0]         r_first_count;
    logic [CNT_W-1:0]         r_second_count;
    logic                     r_dropped;
    logic signed [COEF_W-1:0] r_a;
    logic signed [COEF_W-1:0] r_b;
    logic                     r_v1;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_v2;
    logic signed [ACC_W-1:0]  r_acc;
    t_ipm_result              r_result;
    logic                     r_valid;
    logic                     w_first_full;
    logic                     w_second_full;
    logic                     w_clear_lists;

    assign w_first_full  = (r_first_count  == CNT_W'(MAX_TERMS));
    assign w_second_full = (r_second_count == CNT_W'(MAX_TERMS));
    assign w_clear_lists = (i_cmd.emit && i_cmd.last) || i_cmd.emit_empty;

    // Write loaded coefficients into the lists
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_first && !w_first_full) begin
            r_first_mem[r_first_count[IDX_W-1:0]] <= i_coef;
        end
        if (i_cmd.load_second && !w_second_full) begin
            r_second_mem[r_second_count[IDX_W-1:0]] <= i_coef;
        end
    end

    // Read both lists, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_a <= r_first_mem[i_cmd.first_addr];
            r_b <= r_second_mem[i_cmd.second_addr];
        end
    end

    // Track list fill and the sticky drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_count  <= '0;
            r_second_count <= '0;
            r_dropped      <= 1'b0;
        end else if (w_clear_lists) begin
            r_first_count  <= '0;
            r_second_count <= '0;
            r_dropped      <= 1'b0;
        end else begin
            if (i_cmd.load_first) begin
                if (w_first_full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_first_count <= r_first_count + CNT_W'(1);
                end
            end
            if (i_cmd.load_second) begin
                if (w_second_full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_second_count <= r_second_count + CNT_W'(1);
                end
            end
        end
    end

    // Advance the multiply pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    // Multiply, then accumulate the sign-extended product
    always_ff @(posedge i_clk) begin
        r_prod <= r_a * r_b;
        if (i_cmd.acc_clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Capture the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_empty) begin
            r_result.product_coef <= '0;
            r_result.coef_index   <= '0;
            r_result.last_coef    <= 1'b1;
            r_result.status       <= STATUS_EMPTY;
        end else if (i_cmd.emit) begin
            r_result.product_coef <= r_acc;
            r_result.coef_index   <= i_cmd.index;
            r_result.last_coef    <= i_cmd.last;
            r_result.status       <= r_dropped ? STATUS_DROPPED : STATUS_OK;
        end
    end

    // Strobe each result for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit || i_cmd.emit_empty;
        end
    end

    assign o_stat.first_count  = r_first_count;
    assign o_stat.second_count = r_second_count;
    assign o_result            = r_result;
    assign o_valid             = r_valid;

endmodule

// ===== design/ipm_ctrl.sv =====
// Controller: walks product coefficients and their terms, sequencing the datapath.
`timescale 1ns / 1ps
module ipm_ctrl
    import ipm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_req_type,
    input  t_ipm_stat  i_stat,
    output t_ipm_cmd   o_cmd,
    output logic       o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMPTY,
        S_SETUP,
        S_ISSUE,
        S_DRAIN1,
        S_DRAIN2,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [K_W-1:0]   r_k;
    logic [K_W-1:0]   r_last_k;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_jhi;

    logic [CMP_W-1:0] w_k_e;
    logic [CMP_W-1:0] w_j_e;
    logic [CMP_W-1:0] w_fc_e;
    logic [CMP_W-1:0] w_sc_e;
    logic [CMP_W-1:0] w_jlo;
    logic [CMP_W-1:0] w_jhi;
    logic [CMP_W-1:0] w_len;
    logic [CMP_W-1:0] w_len_cap;
    logic [CMP_W-1:0] w_first_addr;
    logic             w_any_empty;

    // Term range for the current power: first index stays below its count
    assign w_k_e       = CMP_W'(r_k);
    assign w_j_e       = CMP_W'(r_j);
    assign w_fc_e      = CMP_W'(i_stat.first_count);
    assign w_sc_e      = CMP_W'(i_stat.second_count);
    assign w_jlo       = (w_k_e >= w_fc_e) ? (w_k_e - w_fc_e + CMP_W'(1)) : '0;
    assign w_jhi       = (w_k_e < w_sc_e - CMP_W'(1)) ? w_k_e : (w_sc_e - CMP_W'(1));
    assign w_len       = w_fc_e + w_sc_e - CMP_W'(1);
    assign w_len_cap   = (w_len > CMP_W'(RESULT_LIMIT)) ? CMP_W'(RESULT_LIMIT) : w_len;
    assign w_first_addr = w_k_e - w_j_e;
    assign w_any_empty = (i_stat.first_count == '0) || (i_stat.second_count == '0);

    // Hold state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_last_k <= '0;
            r_j      <= '0;
            r_jhi    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_accept && i_req_type == REQ_COMPUTE) begin
                        if (w_any_empty) begin
                            r_state <= S_EMPTY;
                        end else begin
                            r_state  <= S_SETUP;
                            r_k      <= '0;
                            r_last_k <= K_W'(w_len_cap - CMP_W'(1));
                        end
                    end
                end
                S_EMPTY: begin
                    r_state <= S_IDLE;
                end
                S_SETUP: begin
                    r_j     <= w_jlo[IDX_W-1:0];
                    r_jhi   <= w_jhi[IDX_W-1:0];
                    r_state <= S_ISSUE;
                end
                S_ISSUE: begin
                    if (r_j == r_jhi) begin
                        r_state <= S_DRAIN1;
                    end else begin
                        r_j <= r_j + IDX_W'(1);
                    end
                end
                S_DRAIN1: begin
                    r_state <= S_DRAIN2;
                end
                S_DRAIN2: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_k == r_last_k) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + K_W'(1);
                        r_state <= S_SETUP;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Drive datapath commands
    always_comb begin
        o_cmd             = '0;
        o_cmd.load_first  = (r_state == S_IDLE) && i_accept && (i_req_type == REQ_LOAD_FIRST);
        o_cmd.load_second = (r_state == S_IDLE) && i_accept && (i_req_type == REQ_LOAD_SECOND);
        o_cmd.acc_clear   = (r_state == S_SETUP);
        o_cmd.issue       = (r_state == S_ISSUE);
        o_cmd.first_addr  = w_first_addr[IDX_W-1:0];
        o_cmd.second_addr = r_j;
        o_cmd.emit        = (r_state == S_EMIT);
        o_cmd.emit_empty  = (r_state == S_EMPTY);
        o_cmd.last        = (r_k == r_last_k);
        o_cmd.index       = r_k;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== design/integer_polynomial_multiplier.sv =====
// Top level: integer polynomial multiplier with request port and result strobe.
`timescale 1ns / 1ps
// Load requests append one signed 16-bit coefficient to the first or second list
// (lowest power first); a load to a full list is dropped and flags status 2 on
// the next product. A compute request emits every product coefficient in
// ascending power, one result per o_valid pulse, with exact 36-bit sums; the
// receiver cannot stall, so each result must be taken in the cycle it is shown.
// One shared 16x16 multiplier walks the terms: for each coefficient k the
// controller steps through setup, one issue per term pair contributing to it,
// drain1, drain2 and emit. A compute with either list empty returns a single
// zero result with status 1. busy stays high from the accepted compute and
// drops in the cycle its final result is strobed; both lists are empty
// afterward. Request code 3 is ignored.
module integer_polynomial_multiplier
    import ipm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_ipm_req    i_req,
    output t_ipm_result o_result,
    output logic        o_valid
);

    t_ipm_cmd  w_cmd;
    t_ipm_stat w_stat;
    logic      w_busy;
    logic      w_accept;

    assign w_accept = start && !w_busy;
    assign busy     = w_busy;

    ipm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_req_type (i_req.req_type),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    ipm_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_coef   (i_req.coef_value),
        .o_stat   (w_stat),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

    // Result strobes are never back to back
    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");

    // An accepted compute makes the block busy
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type == REQ_COMPUTE) |=> busy)
        else $error("compute accepted without going busy");

    // Empty-operand result is a lone zero marked last
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == STATUS_EMPTY) |->
            (o_result.last_coef && o_result.product_coef == '0
             && o_result.coef_index == '0))
        else $error("malformed empty-operand result");

    // Final result releases busy
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last_coef) |-> !busy)
        else $error("still busy at final result");

endmodule
